>>> hdl/i2cqts_pkg.sv
// Shared types, codes and constants of the queued I2C transaction sequencer.
package i2cqts_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam logic [7:0] BUSY_TIMEOUT_RST = 8'd117;
	localparam logic RD_BIT = 1'b1;

	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 32;
	localparam int CMD_W = 4;
	localparam int ACT_W = 3;
	localparam int SLOT_W = 40;

	// request codes (s_tuser)
	localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
	localparam logic [CMD_W-1:0] CMD_TASK = 4'd1;
	localparam logic [CMD_W-1:0] CMD_START_SENT = 4'd2;
	localparam logic [CMD_W-1:0] CMD_ADDR_ACKED = 4'd3;
	localparam logic [CMD_W-1:0] CMD_BYTE_DONE = 4'd4;
	localparam logic [CMD_W-1:0] CMD_BUS_ERROR = 4'd5;
	localparam logic [CMD_W-1:0] CMD_BULK_WR_DONE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_BULK_RD_DONE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_TICK = 4'd8;

	// bus action codes (m_tuser)
	localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SEND = 3'd2;
	localparam logic [ACT_W-1:0] ACT_BULK_WR = 3'd3;
	localparam logic [ACT_W-1:0] ACT_BULK_RD = 3'd4;
	localparam logic [ACT_W-1:0] ACT_STOP = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NACK_STOP = 3'd6;
	localparam logic [ACT_W-1:0] ACT_REINIT = 3'd7;

	// queued command, as held in one slot
	typedef struct packed {
		logic [7:0] read_len;
		logic [7:0] first_write_byte;
		logic [7:0] write_len;
		logic [7:0] prefix_byte;
		logic       has_prefix;
		logic [6:0] dev_addr;
	} slot_t;

	typedef struct packed {
		logic [5:0] pad;
		logic       is_nack;
		logic       bus_busy;
		logic [7:0] rx_byte;
		slot_t      slot;
	} in_item_t;

	typedef struct packed {
		logic [3:0] pad;
		logic       error_flag;
		logic       overflow;
		logic [7:0] read_data;
		logic       done_status;
		logic       done_valid;
		logic [7:0] out_len;
		logic [7:0] out_byte;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic scan_adv;
		logic exec;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic head_valid;
		logic err_pending;
	} ctl_sts_t;

endpackage

>>> hdl/i2cqts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cqts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/i2cqts_ctrl.sv
// Controller: request sequencing, queue scan stepping and output handshake.
module i2cqts_ctrl import i2cqts_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CMD_W-1:0] s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  ctl_sts_t         sts,
	output ctl_cmd_t         ctl
);

	localparam int CW = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD,
		ST_EXEC
	} state_t;

	state_t        state_q;
	logic [CW-1:0] scan_cnt_q;
	logic          m_tvalid_q;
	logic          is_task;

	assign is_task = (s_tuser == CMD_TASK) || (s_tuser == CMD_TICK);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		ctl = '0;
		ctl.latch = s_tvalid && (state_q == ST_IDLE);
		ctl.scan_adv = (state_q == ST_SCAN) && !sts.head_valid;
		ctl.exec = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					scan_cnt_q <= '0;
					if (ctl.latch) begin
						if (!is_task) begin
							state_q <= ST_RD;
						end else if (sts.err_pending) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (sts.head_valid) begin
						state_q <= ST_RD;
					end else if (scan_cnt_q == CW'(QUEUE_DEPTH - 1)) begin
						state_q <= ST_EXEC;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ctl.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/i2cqts_dp.sv
// Datapath: command queue, phase tracking, busy timer and step evaluation.
module i2cqts_dp import i2cqts_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic                  cfg_valid,
	input  logic [7:0]            cfg_data,
	input  ctl_cmd_t              ctl,
	output ctl_sts_t              sts,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [ACT_W-1:0]      m_tuser
);

	localparam int IW = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		PH_PENDING,
		PH_WRITE,
		PH_WR_BYTE,
		PH_WR_SINGLE,
		PH_WR_MANY,
		PH_READ,
		PH_RD_SINGLE,
		PH_RD_MANY
	} phase_t;

	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [IW-1:0]          rd_idx_q;
	logic [IW-1:0]          wr_idx_q;
	phase_t                 phase_q;
	logic                   err_q;
	logic [7:0]             timer_q;
	logic [7:0]             timeout_q;
	in_item_t               in_q;
	logic [CMD_W-1:0]       cmd_q;
	out_item_t              out_q;
	logic [ACT_W-1:0]       act_q;

	logic [SLOT_W-1:0] ram_rdata;
	slot_t             hd;
	logic              head_v;

	out_item_t        res;
	logic [ACT_W-1:0] act;
	phase_t           ph_n;
	logic             err_n;
	logic             drop;
	logic             tmr_clr;
	logic             add_wr;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
		idx_inc = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	i2cqts_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk(clk),
		.we(ctl.exec && add_wr),
		.waddr(wr_idx_q),
		.wdata(in_q.slot),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign hd = slot_t'(ram_rdata);
	assign head_v = valid_q[rd_idx_q];
	assign sts.head_valid = head_v;
	assign sts.err_pending = err_q;
	assign m_tdata = out_q;
	assign m_tuser = act_q;

	// one step of the sequencer, evaluated with the head slot read out
	always_comb begin
		res = '0;
		act = ACT_NONE;
		ph_n = phase_q;
		err_n = err_q;
		drop = 1'b0;
		tmr_clr = 1'b0;
		add_wr = 1'b0;
		case (cmd_q)
			CMD_ADD: begin
				if (valid_q[wr_idx_q]) begin
					res.overflow = 1'b1;
				end else begin
					add_wr = 1'b1;
				end
			end
			CMD_TASK, CMD_TICK: begin
				if (err_q) begin
					err_n = 1'b0;
					act = ACT_REINIT;
				end else if (head_v && phase_q == PH_PENDING) begin
					if (hd.write_len == 8'd0 && !hd.has_prefix) begin
						res.done_valid = 1'b1;
						res.done_status = 1'b1;
						drop = 1'b1;
					end else if (in_q.bus_busy) begin
						if (timer_q >= timeout_q) begin
							tmr_clr = 1'b1;
							err_n = 1'b1;
						end
					end else begin
						ph_n = PH_WRITE;
						act = ACT_START;
					end
				end
			end
			CMD_START_SENT: begin
				if (!head_v) begin
					err_n = 1'b1;
				end else begin
					act = ACT_SEND;
					res.out_byte = {hd.dev_addr, (phase_q == PH_WRITE) ? 1'b0 : RD_BIT};
				end
			end
			CMD_ADDR_ACKED: begin
				if (!head_v) begin
					err_n = 1'b1;
				end else if (phase_q == PH_WRITE) begin
					if (hd.has_prefix) begin
						act = ACT_SEND;
						res.out_byte = hd.prefix_byte;
						ph_n = PH_WR_BYTE;
					end else if (hd.write_len == 8'd1) begin
						act = ACT_SEND;
						res.out_byte = hd.first_write_byte;
						ph_n = PH_WR_SINGLE;
					end else begin
						act = ACT_BULK_WR;
						res.out_len = hd.write_len;
						ph_n = PH_WR_MANY;
					end
				end else if (phase_q == PH_READ) begin
					if (hd.read_len == 8'd1) begin
						act = ACT_NACK_STOP;
						ph_n = PH_RD_SINGLE;
					end else begin
						act = ACT_BULK_RD;
						res.out_len = hd.read_len;
						ph_n = PH_RD_MANY;
					end
				end
			end
			CMD_BYTE_DONE: begin
				if (!head_v) begin
					err_n = 1'b1;
				end else if ((phase_q == PH_WR_BYTE && hd.write_len == 8'd0) ||
						phase_q == PH_WR_SINGLE) begin
					// write part finished
					if (hd.read_len == 8'd0) begin
						res.done_valid = 1'b1;
						act = ACT_STOP;
						drop = 1'b1;
						tmr_clr = 1'b1;
					end else begin
						ph_n = PH_READ;
						act = ACT_START;
					end
				end else if (phase_q == PH_WR_BYTE) begin
					if (hd.write_len == 8'd1) begin
						act = ACT_SEND;
						res.out_byte = hd.first_write_byte;
						ph_n = PH_WR_SINGLE;
					end else begin
						act = ACT_BULK_WR;
						res.out_len = hd.write_len;
						ph_n = PH_WR_MANY;
					end
				end else if (phase_q == PH_RD_SINGLE) begin
					res.read_data = in_q.rx_byte;
					res.done_valid = 1'b1;
					drop = 1'b1;
				end
			end
			CMD_BUS_ERROR: begin
				if (head_v) begin
					res.done_valid = 1'b1;
					res.done_status = 1'b1;
					drop = 1'b1;
					if (in_q.is_nack) begin
						act = ACT_STOP;
						tmr_clr = 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end else begin
					err_n = 1'b1;
				end
			end
			CMD_BULK_WR_DONE: begin
				if (head_v && phase_q == PH_WR_MANY) begin
					if (hd.read_len == 8'd0) begin
						res.done_valid = 1'b1;
						act = ACT_STOP;
						drop = 1'b1;
						tmr_clr = 1'b1;
					end else begin
						ph_n = PH_READ;
						act = ACT_START;
					end
				end
			end
			CMD_BULK_RD_DONE: begin
				if (head_v && phase_q == PH_RD_MANY) begin
					res.done_valid = 1'b1;
					act = ACT_STOP;
					drop = 1'b1;
					tmr_clr = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (drop) begin
			ph_n = PH_PENDING;
		end
		res.error_flag = err_n;
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			in_q <= in_item_t'(s_tdata);
			cmd_q <= s_tuser;
		end
		if (ctl.exec) begin
			out_q <= res;
			act_q <= act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			phase_q <= PH_PENDING;
			err_q <= 1'b0;
			timer_q <= '0;
			timeout_q <= BUSY_TIMEOUT_RST;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (ctl.latch && s_tuser == CMD_TICK && timer_q != 8'hFF) begin
				timer_q <= timer_q + 8'd1;
			end
			if (ctl.scan_adv) begin
				rd_idx_q <= idx_inc(rd_idx_q);
				phase_q <= PH_PENDING;
			end
			if (ctl.exec) begin
				phase_q <= ph_n;
				err_q <= err_n;
				if (tmr_clr) begin
					timer_q <= '0;
				end
				if (drop) begin
					valid_q[rd_idx_q] <= 1'b0;
					rd_idx_q <= idx_inc(rd_idx_q);
				end
				if (add_wr) begin
					valid_q[wr_idx_q] <= 1'b1;
					wr_idx_q <= idx_inc(wr_idx_q);
				end
			end
		end
	end

endmodule

>>> hdl/i2c_queued_transaction_sequencer_core.sv
// Top level of the queued I2C master transaction sequencer.
//
// Queues I2C master commands (address, optional prefix byte, write length with
// first byte, read length) in a ring of QUEUE_DEPTH slots and sequences them
// on bus events: one request in gives exactly one result out, carrying the bus
// action to perform and the completion status of the current command. Add and
// bus-event requests pass through latch, slot RAM read and evaluate before the
// next input slot is free. Task and tick requests walk the valid bits one slot
// per cycle from the head to the oldest queued command before evaluation; when
// a bus reinit is pending they skip the walk and go straight to evaluation. The
// result sits in an output register, so a new request is taken while the last
// result still waits for m_tready. A command that fails on a non-NACK bus error
// is dropped and error_flag stays high until the next task or tick, which
// answers with a bus reinit. busy_timeout_ticks (cfg_data, reset 117) sets how
// many ticks after a stop a still-busy bus is tolerated; write it only while
// the block is idle. cfg_ready is always high.
module i2c_queued_transaction_sequencer_core import i2cqts_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// dev_addr[6:0], has_prefix[7], prefix_byte[15:8], write_len[23:16],
	// first_write_byte[31:24], read_len[39:32], rx_byte[47:40], bus_busy[48],
	// is_nack[49], zero pad[55:50]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[3:0]
	input  logic [CMD_W-1:0]      s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_byte[7:0], out_len[15:8], done_valid[16], done_status[17],
	// read_data[25:18], overflow[26], error_flag[27], zero pad[31:28]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// action[2:0]
	output logic [ACT_W-1:0]      m_tuser,
	// busy_timeout_ticks write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	ctl_cmd_t  ctl;
	ctl_sts_t  sts;
	out_item_t mon;

	assign cfg_ready = 1'b1;

	// sequencing: accept, scan, RAM read, evaluate, hand to output register
	i2cqts_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.ctl(ctl)
	);

	// queue storage, phase, busy timer and result formation
	i2cqts_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.ctl(ctl),
		.sts(sts),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	assign mon = out_item_t'(m_tdata);

	// a reinit always clears the pending error
	a_reinit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_REINIT |-> !mon.error_flag)
		else $error("reinit result with error still pending");

	// failure status only with a finished command
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mon.done_status |-> mon.done_valid)
		else $error("done_status without done_valid");

	// a rejected add does nothing else
	a_overflow_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mon.overflow |-> m_tuser == ACT_NONE && !mon.done_valid)
		else $error("overflow result carries an action or completion");

	// read data only comes with the single-byte read completion
	a_rdata_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mon.read_data != 8'd0 |-> mon.done_valid && !mon.done_status)
		else $error("read_data outside a successful completion");

endmodule
